// ===== design/csdn_pkg.sv =====
`timescale 1ns / 1ps

package csdn_pkg;

    // step modes
    localparam logic [3:0] MODE_NEXT_HOUR   = 4'd0;
    localparam logic [3:0] MODE_PREV_HOUR   = 4'd1;
    localparam logic [3:0] MODE_NEXT_DAY    = 4'd2;
    localparam logic [3:0] MODE_PREV_DAY    = 4'd3;
    localparam logic [3:0] MODE_NEXT_WEEK   = 4'd4;
    localparam logic [3:0] MODE_PREV_WEEK   = 4'd5;
    localparam logic [3:0] MODE_NEXT_MONTH  = 4'd6;
    localparam logic [3:0] MODE_PREV_MONTH  = 4'd7;
    localparam logic [3:0] MODE_NEXT_YEAR   = 4'd8;
    localparam logic [3:0] MODE_PREV_YEAR   = 4'd9;
    localparam logic [3:0] MODE_MONTH_START = 4'd10;

    localparam int YEAR_MIN = 1901;
    localparam int YEAR_MAX = 2099;

    // input date plus step mode
    typedef struct packed {
        logic [3:0]  mode;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } date_in_t;

    // stepped date; year is kept wide so that 0 - 1 and 4095 + 1 stay exact
    typedef struct packed {
        logic signed [13:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
    } date_step_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [16:0] day_number;
        logic [8:0]  day_of_year;
        logic        out_of_range;
    } date_out_t;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:                       r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
            default:                    r = 5'd31;
        endcase
        return r;
    endfunction

    // floor(275 * m / 9)
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd213;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd366;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/csdn_step.sv =====
`timescale 1ns / 1ps

module csdn_step
(
    input  csdn_pkg::date_in_t   din,
    output csdn_pkg::date_step_t dout
);
    import csdn_pkg::*;

    logic [3:0]         m_c;
    logic [5:0]         d_c;
    logic [4:0]         h_c;
    logic signed [13:0] y_c;
    logic [11:0]        q25;
    logic [24:0]        prod;
    logic [16:0]        q25_x25;
    logic               div4;
    logic               div25;
    logic               div16;
    logic               leap;
    logic [5:0]         dim_cur;
    logic [5:0]         dim_prev;
    logic [3:0]         m_fwd;
    logic [3:0]         m_back;
    logic signed [13:0] y_fwd;
    logic signed [13:0] y_back;
    logic signed [13:0] y_s;
    logic [3:0]         m_s;
    logic [5:0]         d_s;
    logic [4:0]         h_s;

    // clamp odd codes
    assign m_c = (din.month == 4'd0) ? 4'd1 : ((din.month > 4'd12) ? 4'd12 : din.month);
    assign d_c = (din.day == 5'd0) ? 6'd1 : {1'b0, din.day};
    assign h_c = (din.hour > 5'd23) ? 5'd23 : din.hour;
    assign y_c = {2'b00, din.year};

    // leap test: year/25 by reciprocal (exact below 4096), century when /4 and /25
    assign prod    = {13'd0, din.year} * 25'd5243;
    assign q25     = {4'd0, prod[24:17]};
    assign q25_x25 = {5'd0, q25} * 17'd25;
    assign div25   = (q25_x25 == {5'd0, din.year});
    assign div4    = (din.year[1:0] == 2'b00);
    assign div16   = (din.year[3:0] == 4'b0000);
    assign leap    = div4 && (!div25 || div16);

    // a step back from January is the only one that needs a length in another year,
    // and December has no leap dependence, so the input year decides both lengths
    assign m_fwd    = (m_c == 4'd12) ? 4'd1 : m_c + 4'd1;
    assign y_fwd    = (m_c == 4'd12) ? y_c + 14'sd1 : y_c;
    assign m_back   = (m_c == 4'd1) ? 4'd12 : m_c - 4'd1;
    assign y_back   = (m_c == 4'd1) ? y_c - 14'sd1 : y_c;
    assign dim_cur  = {1'b0, month_days(m_c, leap)};
    assign dim_prev = {1'b0, month_days(m_back, leap)};

    always_comb
    begin
        y_s = y_c;
        m_s = m_c;
        d_s = d_c;
        h_s = h_c;
        case (din.mode)
            MODE_NEXT_HOUR:
            begin
                if (h_c == 5'd23)
                begin
                    h_s = 5'd0;
                    if (d_c + 6'd1 > dim_cur)
                    begin
                        d_s = 6'd1;
                        m_s = m_fwd;
                        y_s = y_fwd;
                    end
                    else
                    begin
                        d_s = d_c + 6'd1;
                    end
                end
                else
                begin
                    h_s = h_c + 5'd1;
                end
            end
            MODE_PREV_HOUR:
            begin
                if (h_c == 5'd0)
                begin
                    h_s = 5'd23;
                    if (d_c == 6'd1)
                    begin
                        d_s = dim_prev;
                        m_s = m_back;
                        y_s = y_back;
                    end
                    else
                    begin
                        d_s = d_c - 6'd1;
                    end
                end
                else
                begin
                    h_s = h_c - 5'd1;
                end
            end
            MODE_NEXT_DAY:
            begin
                if (d_c + 6'd1 > dim_cur)
                begin
                    d_s = 6'd1;
                    m_s = m_fwd;
                    y_s = y_fwd;
                end
                else
                begin
                    d_s = d_c + 6'd1;
                end
            end
            MODE_PREV_DAY:
            begin
                if (d_c == 6'd1)
                begin
                    d_s = dim_prev;
                    m_s = m_back;
                    y_s = y_back;
                end
                else
                begin
                    d_s = d_c - 6'd1;
                end
            end
            MODE_NEXT_WEEK:
            begin
                if (d_c + 6'd7 > dim_cur)
                begin
                    d_s = d_c + 6'd7 - dim_cur;
                    m_s = m_fwd;
                    y_s = y_fwd;
                end
                else
                begin
                    d_s = d_c + 6'd7;
                end
            end
            MODE_PREV_WEEK:
            begin
                if (d_c <= 6'd7)
                begin
                    d_s = d_c + dim_prev - 6'd7;
                    m_s = m_back;
                    y_s = y_back;
                end
                else
                begin
                    d_s = d_c - 6'd7;
                end
            end
            MODE_NEXT_MONTH:
            begin
                m_s = m_fwd;
                y_s = y_fwd;
            end
            MODE_PREV_MONTH:
            begin
                m_s = m_back;
                y_s = y_back;
            end
            MODE_NEXT_YEAR:
            begin
                y_s = y_c + 14'sd1;
            end
            MODE_PREV_YEAR:
            begin
                y_s = y_c - 14'sd1;
            end
            MODE_MONTH_START:
            begin
                if (!(d_c == 6'd1 && h_c == 5'd0))
                begin
                    m_s = m_fwd;
                    y_s = y_fwd;
                    d_s = 6'd1;
                    h_s = 5'd0;
                end
            end
            default:
            begin
                y_s = y_c;
            end
        endcase
    end

    assign dout.year  = y_s;
    assign dout.month = m_s;
    assign dout.day   = d_s[4:0];
    assign dout.hour  = h_s;

endmodule

// ===== design/csdn_daynum.sv =====
`timescale 1ns / 1ps

module csdn_daynum
(
    input  csdn_pkg::date_step_t din,
    output csdn_pkg::date_out_t  dout
);
    import csdn_pkg::*;

    logic        oor;
    logic        past_feb;
    logic [8:0]  moff;
    logic [11:0] y12;
    logic [20:0] y367;
    logic [14:0] y7;
    logic [12:0] y7q;
    logic [20:0] dn_sum;
    logic [9:0]  doy_sum;
    logic [1:0]  doy_adj;

    assign oor      = (din.year < 14'(YEAR_MIN)) || (din.year > 14'(YEAR_MAX));
    assign past_feb = (din.month >= 4'd3);
    assign moff     = month_offset(din.month);
    assign y12      = din.year[11:0];

    // 367*y - floor(7*(y + [m>2]) / 4) + floor(275*m/9) + d - 694006
    assign y367   = {9'd0, y12} * 21'd367;
    assign y7     = ({3'd0, y12} + {14'd0, past_feb}) * 15'd7;
    assign y7q    = y7[14:2];
    assign dn_sum = y367 + {12'd0, moff} + {16'd0, din.day}
                  - {8'd0, y7q} - 21'd694006;

    // day of year: the year terms cancel but for one or two days after February
    assign doy_adj = past_feb ? ((din.year[1:0] == 2'b00) ? 2'd1 : 2'd2) : 2'd0;
    assign doy_sum = {1'b0, moff} + {5'd0, din.day} - 10'd30 - {8'd0, doy_adj};

    assign dout.year         = y12;
    assign dout.month        = din.month;
    assign dout.day          = din.day;
    assign dout.hour         = din.hour;
    assign dout.day_number   = oor ? 17'd0 : dn_sum[16:0];
    assign dout.day_of_year  = doy_sum[8:0];
    assign dout.out_of_range = oor;

endmodule

// ===== design/calendar_step_and_day_number_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Bits  Contents
// s_axis    in   32+4  tdata: year, month, day, hour; tuser: step mode
// m_axis    out  56+1  tdata: year, month, day, hour, day number, day of year;
//                      tuser: out of range flag
//
// Two register stages: the input beat is captured, the date step and the
// day-number arithmetic run in one combinational pass, the result register
// holds the output beat. One beat per cycle is sustained while m_axis takes
// its beats. Reset clears only the two valid flags. A stall on m_axis freezes
// both stages; the input stage keeps taking beats while it has room.

module calendar_step_and_day_number_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] year_in, [15:12] month_in, [20:16] day_in, [25:21] hour_in, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    // [3:0] mode
    input  logic [3:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [11:0] year_out, [15:12] month_out, [20:16] day_out, [25:21] hour_out,
    // [42:26] day_number, [51:43] day_of_year, [55:52] zero
    output logic [55:0] m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]  m_axis_tuser
);
    import csdn_pkg::*;

    logic       in_vld_reg;
    logic       in_vld_next;
    date_in_t   in_reg;
    logic       out_vld_reg;
    logic       out_vld_next;
    date_out_t  out_reg;
    logic       advance;
    date_step_t stepped;
    date_out_t  result;

    // the result stage moves when it is empty or its beat is taken
    assign advance       = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || advance;
    assign in_vld_next   = s_axis_tready ? s_axis_tvalid : in_vld_reg;
    assign out_vld_next  = advance ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg.mode  <= s_axis_tuser;
            in_reg.year  <= s_axis_tdata[11:0];
            in_reg.month <= s_axis_tdata[15:12];
            in_reg.day   <= s_axis_tdata[20:16];
            in_reg.hour  <= s_axis_tdata[25:21];
        end
        if (advance && in_vld_reg)
        begin
            out_reg <= result;
        end
    end

    // clamp and step the date
    csdn_step u_step
    (
        .din  (in_reg),
        .dout (stepped)
    );

    // day count since 1900 and day of year
    csdn_daynum u_daynum
    (
        .din  (stepped),
        .dout (result)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, out_reg.day_of_year, out_reg.day_number, out_reg.hour,
                            out_reg.day, out_reg.month, out_reg.year};
    assign m_axis_tuser  = out_reg.out_of_range;

endmodule
